/* rtl/lkv_pkg.sv */
// Shared constants, command codes and link types for the LRU key-value cache.
package lkv_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 16;
	localparam int VALUE_BITS = 32;
	localparam int CAP_BITS   = 5;
	localparam int RANK_BITS  = $clog2(ENTRIES);
	localparam int OCC_BITS   = $clog2(ENTRIES + 1);

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	// update applied to the cell row in the update cycle of a request
	typedef enum logic [1:0] {
		UPD_NONE,
		UPD_HIT,
		UPD_EVICT,
		UPD_FILL
	} upd_mode_t;

	typedef struct packed {
		upd_mode_t              mode;
		logic                   is_put;
		logic [KEY_BITS-1:0]    key;
		logic [VALUE_BITS-1:0]  value;
		logic [RANK_BITS-1:0]   rank;     // rank of the touched entry
		logic                   age_all;  // every other valid entry ages
	} upd_cmd_t;

	// carried from cell to cell along the row
	typedef struct packed {
		logic                   hit;
		logic                   free_seen;
		logic [VALUE_BITS-1:0]  value;
		logic [RANK_BITS-1:0]   rank;
	} link_t;

endpackage

/* rtl/lru_key_value_cache.sv */
// Top level: fully associative key-value cache with least-recently-used replacement.
//
//  channel   handshake              payload
//  -------   ---------------------  -----------------------------------
//  request   start & !busy          action, key, write_value
//  result    done (one cycle)       hit, read_value, evicted
//  config    cfg_we                 cfg_wdata (capacity in use)
//
// Each request passes through a compare cycle, where every cell checks
// its key and the hit, value, rank and first-free chains ripple along the
// row, then an update cycle that ages ranks and writes the chosen cell.
// busy covers only the compare cycle, so a new request can be accepted
// during the previous request's update cycle; the result appears in the cycle after the update cycle.
// Reset clears valid marks, ranks, occupancy and sets capacity to ENTRIES.
// The receiver cannot stall: done is a one-cycle strobe.
module lru_key_value_cache
	import lkv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  action,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] write_value,
	output logic                  done,
	output logic                  hit,
	output logic [VALUE_BITS-1:0] read_value,
	output logic                  evicted,
	input  logic                  cfg_we,
	input  logic [CAP_BITS-1:0]   cfg_wdata
);

	// request stage (compare cycle)
	logic                  valid_s1, action_s1;
	logic [KEY_BITS-1:0]   key_s1;
	logic [VALUE_BITS-1:0] value_s1;

	// update stage
	logic                  valid_s2, action_s2, hit_s2;
	logic [KEY_BITS-1:0]   key_s2;
	logic [VALUE_BITS-1:0] value_s2, rval_s2;
	logic [RANK_BITS-1:0]  hrank_s2;

	logic [CAP_BITS-1:0]   cap_q;
	logic [OCC_BITS-1:0]   occ_q, occ_m1;

	logic                  done_q, hit_q, evicted_q;
	logic [VALUE_BITS-1:0] read_value_q;

	link_t                 links [ENTRIES+1];
	logic [ENTRIES-1:0]    valid_vec;
	upd_cmd_t              cmd;
	logic                  accept;

	assign accept = start && !busy;
	assign busy   = valid_s1;
	assign occ_m1 = occ_q - 1'b1;

	assign links[0] = '{hit: 1'b0, free_seen: 1'b0, value: '0, rank: '0};

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lkv_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.compare  (valid_s1),
			.req_key  (key_s1),
			.lru_rank (occ_m1[RANK_BITS-1:0]),
			.link_in  (links[i]),
			.link_out (links[i+1]),
			.cmd      (cmd),
			.vld      (valid_vec[i])
		);
	end

	// choose the update; occupancy is stable between update edges
	always_comb begin
		cmd.is_put = (action_s2 == ACT_PUT);
		cmd.key    = key_s2;
		cmd.value  = value_s2;
		cmd.rank   = hrank_s2;
		if (!valid_s2)
			cmd.mode = UPD_NONE;
		else if (hit_s2)
			cmd.mode = UPD_HIT;
		else if (action_s2 == ACT_GET)
			cmd.mode = UPD_NONE;
		else if (OCC_BITS'(occ_q) >= OCC_BITS'(cap_q))
			cmd.mode = UPD_EVICT;
		else
			cmd.mode = UPD_FILL;
		// on evict the victim holds the top rank and on fill the new entry is free, so all others age
		cmd.age_all = (cmd.mode == UPD_EVICT) || (cmd.mode == UPD_FILL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			key_s1    <= key;
			value_s1  <= write_value;
		end
		if (valid_s1) begin
			action_s2 <= action_s1;
			key_s2    <= key_s1;
			value_s2  <= value_s1;
			hit_s2    <= links[ENTRIES].hit;
			rval_s2   <= links[ENTRIES].value;
			hrank_s2  <= links[ENTRIES].rank;
		end
	end

	// capacity is clamped to 1..ENTRIES when written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_BITS'(ENTRIES);
		end else if (cfg_we) begin
			if (cfg_wdata == '0)
				cap_q <= CAP_BITS'(1);
			else if (cfg_wdata > CAP_BITS'(ENTRIES))
				cap_q <= CAP_BITS'(ENTRIES);
			else
				cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (cmd.mode == UPD_FILL) begin
			occ_q <= occ_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q       <= 1'b0;
			hit_q        <= 1'b0;
			evicted_q    <= 1'b0;
			read_value_q <= '0;
		end else begin
			done_q       <= valid_s2;
			hit_q        <= valid_s2 && hit_s2;
			evicted_q    <= (cmd.mode == UPD_EVICT);
			read_value_q <= (valid_s2 && hit_s2 && action_s2 == ACT_GET) ? rval_s2 : '0;
		end
	end

	assign done       = done_q;
	assign hit        = hit_q;
	assign evicted    = evicted_q;
	assign read_value = read_value_q;

	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(occ_q))
		else $error("occupancy does not match valid marks");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_BITS'(ENTRIES))
		else $error("occupancy beyond entry count");

	a_stage_flow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> valid_s2 && !valid_s1)
		else $error("compare cycle not followed by update cycle");

	a_result_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done && evicted |-> !hit)
		else $error("eviction reported on a hit");

	a_fill_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mode == UPD_FILL |-> valid_vec != '1)
		else $error("fill with no free entry");

endmodule

/* rtl/lkv_cell.sv */
// One cache entry: key, value, valid mark and recency rank, linked to its neighbors.
module lkv_cell
	import lkv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  compare,
	input  logic [KEY_BITS-1:0]   req_key,
	input  logic [RANK_BITS-1:0]  lru_rank,
	input  link_t                 link_in,
	output link_t                 link_out,
	input  upd_cmd_t              cmd,
	output logic                  vld
);

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  valid_q;
	logic [RANK_BITS-1:0]  rank_q;

	logic match_s2, lru_s2, first_free_s2;
	logic match, sel, age;

	assign match = valid_q && (key_q == req_key);
	assign vld   = valid_q;

	always_comb begin
		link_out.hit       = link_in.hit | match;
		link_out.free_seen = link_in.free_seen | ~valid_q;
		link_out.value     = link_in.value | (match ? value_q : '0);
		link_out.rank      = link_in.rank | (match ? rank_q : '0);
	end

	always_comb begin
		case (cmd.mode)
			UPD_HIT:   sel = match_s2;
			UPD_EVICT: sel = lru_s2;
			UPD_FILL:  sel = first_free_s2;
			default:   sel = 1'b0;
		endcase
		age = (cmd.mode != UPD_NONE) && valid_q && !sel
			&& (cmd.age_all || (rank_q < cmd.rank));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_s2      <= 1'b0;
			lru_s2        <= 1'b0;
			first_free_s2 <= 1'b0;
		end else if (compare) begin
			match_s2      <= match;
			lru_s2        <= valid_q && (rank_q == lru_rank);
			first_free_s2 <= !valid_q && !link_in.free_seen;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= '0;
		end else if (sel) begin
			valid_q <= 1'b1;
			rank_q  <= '0;
		end else if (age) begin
			rank_q <= rank_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sel && cmd.mode != UPD_HIT)
			key_q <= cmd.key;
		if (sel && cmd.is_put)
			value_q <= cmd.value;
	end

endmodule

/* tb/lru_key_value_cache_tb.sv */
// Testbench for the LRU key-value cache: directed and random requests checked against a mirror.
`timescale 1ns / 100ps

module lru_key_value_cache_tb;
	import lkv_pkg::*;

	// one result as the cache should report it
	typedef struct {
		logic                  hit;
		logic [VALUE_BITS-1:0] read_value;
		logic                  evicted;
	} cache_resp_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  action = ACT_GET;
	logic [KEY_BITS-1:0]   key = '0;
	logic [VALUE_BITS-1:0] write_value = '0;
	logic                  done;
	logic                  hit;
	logic [VALUE_BITS-1:0] read_value;
	logic                  evicted;
	logic                  cfg_we = 1'b0;
	logic [CAP_BITS-1:0]   cfg_wdata = '0;

	lru_key_value_cache u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.action     (action),
		.key        (key),
		.write_value(write_value),
		.done       (done),
		.hit        (hit),
		.read_value (read_value),
		.evicted    (evicted),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always #10 clk = ~clk;

	// Fail-safe: a correct run ends far earlier than this.
	initial begin
		#20_000_000;
		$display("[lru_key_value_cache] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Mirror of the cache contents, the recency order and the capacity.
	// ------------------------------------------------------------------
	logic [KEY_BITS-1:0]   m_key   [ENTRIES];
	logic [VALUE_BITS-1:0] m_val   [ENTRIES];
	logic                  m_valid [ENTRIES];
	logic [RANK_BITS-1:0]  m_rank  [ENTRIES];  // 0 = most recent
	logic [OCC_BITS-1:0]   m_occ;
	logic [CAP_BITS-1:0]   m_cap;

	cache_resp_t resp_q[$];   // results still owed by the cache
	int          err_count = 0;
	bit          gaps_on = 1'b1;

	function automatic void clear_mirror();
		for (int i = 0; i < ENTRIES; i++) begin
			m_valid[i] = 1'b0;
			m_rank[i]  = '0;
			m_key[i]   = '0;
			m_val[i]   = '0;
		end
		m_occ = '0;
		m_cap = CAP_BITS'(ENTRIES);
	endfunction

	// make slot s most recent; the entries that were ahead of it age by one
	function automatic void promote(int s);
		logic [RANK_BITS-1:0] r;
		r = m_rank[s];
		for (int i = 0; i < ENTRIES; i++)
			if (m_valid[i] && i != s && m_rank[i] < r)
				m_rank[i] = m_rank[i] + 1'b1;
		m_rank[s] = '0;
	endfunction

	// apply one get or put to the mirror and return what the cache must report
	function automatic cache_resp_t predict_access(logic act, logic [KEY_BITS-1:0] k,
			logic [VALUE_BITS-1:0] v);
		cache_resp_t          r;
		int                   cap;
		int                   slot;
		bit                   found;
		bit                   any;
		logic [RANK_BITS-1:0] oldest;
		r = '{hit: 1'b0, read_value: '0, evicted: 1'b0};
		cap = int'(m_cap);
		if (cap < 1) cap = 1;
		if (cap > ENTRIES) cap = ENTRIES;
		slot = 0;
		found = 1'b0;
		for (int i = 0; i < ENTRIES; i++)
			if (!found && m_valid[i] && m_key[i] == k) begin
				slot = i;
				found = 1'b1;
			end
		if (act == ACT_GET) begin
			if (found) begin
				r.hit = 1'b1;
				r.read_value = m_val[slot];
				promote(slot);
			end
		end else if (found) begin
			r.hit = 1'b1;
			m_val[slot] = v;
			promote(slot);
		end else if (int'(m_occ) >= cap) begin
			// full for this capacity: replace the least recent entry
			any = 1'b0;
			oldest = '0;
			for (int i = 0; i < ENTRIES; i++)
				if (m_valid[i] && (!any || m_rank[i] > oldest)) begin
					oldest = m_rank[i];
					slot = i;
					any = 1'b1;
				end
			if (any) begin
				r.evicted = 1'b1;
				m_key[slot] = k;
				m_val[slot] = v;
				promote(slot);
			end
		end else begin
			// lowest free slot; every valid entry ages
			any = 1'b0;
			for (int i = 0; i < ENTRIES; i++)
				if (!any && !m_valid[i]) begin
					slot = i;
					any = 1'b1;
				end
			if (any) begin
				for (int i = 0; i < ENTRIES; i++)
					if (m_valid[i])
						m_rank[i] = m_rank[i] + 1'b1;
				m_valid[slot] = 1'b1;
				m_key[slot] = k;
				m_val[slot] = v;
				m_rank[slot] = '0;
				m_occ = m_occ + 1'b1;
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result check. Sampled at the falling edge so the strobe and the
	// payload are settled and no edge ordering matters.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : result_check
		cache_resp_t want;
		if (arst_n && done) begin
			if (resp_q.size() == 0) begin
				$error("result with no request outstanding: hit=%0d read_value=%h evicted=%0d",
					hit, read_value, evicted);
				err_count++;
			end else begin
				want = resp_q.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					err_count++;
				end
				if (read_value !== want.read_value) begin
					$error("read_value: expected %h, got %h", want.read_value, read_value);
					err_count++;
				end
				if (evicted !== want.evicted) begin
					$error("evicted: expected %0d, got %0d", want.evicted, evicted);
					err_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Request driver. Entered and left right after a rising edge. start is
	// left high after acceptance so back-to-back requests need no dip.
	// busy is sampled at the falling edge: it holds through the next rise.
	// ------------------------------------------------------------------
	task automatic send_request(input logic act, input logic [KEY_BITS-1:0] k,
			input logic [VALUE_BITS-1:0] v);
		bit took;
		if (gaps_on)
			while ($urandom_range(0, 99) < 31) begin
				start <= 1'b0;
				@(posedge clk);
			end
		start       <= 1'b1;
		action      <= act;
		key         <= k;
		write_value <= v;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = !busy;
			@(posedge clk);
		end
		resp_q.push_back(predict_access(act, k, v));
	endtask

	// drop start and let every owed result come back
	task automatic drain();
		start <= 1'b0;
		while (resp_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// capacity register is written only while the cache is quiet
	task automatic write_capacity(input logic [CAP_BITS-1:0] c);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_cap = c;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// lookups right after reset all miss
	task automatic test_empty_lookups();
		send_request(ACT_GET, 16'h0000, 32'hFFFF_FFFF);
		send_request(ACT_GET, 16'hFFFF, 32'h0000_0000);
	endtask

	// fills, hits, overwrite of a present key
	task automatic test_put_get_overwrite();
		send_request(ACT_PUT, 16'h0000, 32'h0000_0000);
		send_request(ACT_PUT, 16'hFFFF, 32'hFFFF_FFFF);
		send_request(ACT_GET, 16'h0000, 32'h1234_5678);
		send_request(ACT_GET, 16'hFFFF, 32'h0);
		send_request(ACT_PUT, 16'h0000, 32'h5A5A_A5A5);
		send_request(ACT_GET, 16'h0000, 32'h0);
	endtask

	// capacity dropped to or under the occupancy: puts replace, nothing flushed
	task automatic test_lower_capacity();
		write_capacity(5'd2);
		send_request(ACT_PUT, 16'h1234, 32'hDEAD_BEEF);
		send_request(ACT_GET, 16'hFFFF, 32'h0);
		write_capacity(5'd1);
		send_request(ACT_PUT, 16'h8001, 32'h0BAD_F00D);
		send_request(ACT_GET, 16'h1234, 32'h0);
		send_request(ACT_GET, 16'h0000, 32'h0);
	endtask

	// zero behaves as one, values past the entry count as the entry count
	task automatic test_capacity_clamp();
		write_capacity(5'd0);
		send_request(ACT_PUT, 16'h7FFE, 32'h8000_0001);
		send_request(ACT_GET, 16'h7FFE, 32'h0);
		write_capacity(5'd31);
		send_request(ACT_PUT, 16'h4321, 32'h7FFF_FFFE);
		send_request(ACT_GET, 16'h4321, 32'h0);
	endtask

	// mostly a small pool of keys so gets hit and puts evict, some strays
	task automatic test_random_traffic(input logic [CAP_BITS-1:0] c, input int n,
			input bit steady);
		logic [KEY_BITS-1:0] pool[$];
		int                  eff;
		int                  pool_n;
		logic [KEY_BITS-1:0] k;
		logic                act;
		write_capacity(c);
		gaps_on = !steady;
		eff = int'(c);
		if (eff < 1) eff = 1;
		if (eff > ENTRIES) eff = ENTRIES;
		pool_n = eff + $urandom_range(1, 4);
		for (int i = 0; i < pool_n; i++)
			pool.push_back(KEY_BITS'($urandom_range(0, 65535)));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 85)
				k = pool[$urandom_range(0, pool_n - 1)];
			else
				k = KEY_BITS'($urandom_range(0, 65535));
			act = ($urandom_range(0, 99) < 55) ? ACT_PUT : ACT_GET;
			send_request(act, k, $urandom());
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		clear_mirror();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_lookups();
		test_put_get_overwrite();
		test_lower_capacity();
		test_capacity_clamp();

		test_random_traffic(5'd16, 220, 1'b0);
		test_random_traffic(5'd3,  220, 1'b0);
		test_random_traffic(5'd1,  220, 1'b0);
		test_random_traffic(5'd0,  200, 1'b0);
		test_random_traffic(5'd31, 220, 1'b0);
		test_random_traffic(5'd8,  220, 1'b1);
		test_random_traffic(5'd17, 220, 1'b0);
		test_random_traffic(CAP_BITS'($urandom_range(0, 31)), 220, 1'b0);

		drain();
		repeat (10) @(posedge clk);
		if (err_count == 0 && resp_q.size() == 0) begin
			$display("[lru_key_value_cache] OK");
		end else begin
			$display("[lru_key_value_cache] ERROR");
		end
		$finish;
	end

endmodule
